FILE: src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property on the rising clock, skipped during reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check that a condition never holds on the rising clock, skipped during reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`endif

FILE: src/bpfa_pkg.sv
package bpfa_pkg;

    localparam int ADDR_W     = 64;
    localparam int RANGE_W    = 17;
    localparam int PAGE_NUM_W = 16;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int WORD_W     = 64;
    localparam int BIT_W      = 6;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 17'd65536;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] STS_ALLOCATED    = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FULL         = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FREED        = 3'd2;
    localparam logic [STATUS_W-1:0] STS_ALREADY_FREE = 3'd3;
    localparam logic [STATUS_W-1:0] STS_MARKED       = 3'd4;
    localparam logic [STATUS_W-1:0] STS_OUT_OF_RANGE = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_VIRTUAL_OFFSET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_RANGE     = 8'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_MARK_RD,
        ST_MARK_EV,
        ST_ADDR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             first;
        logic             last;
        logic [BIT_W-1:0] lo_bit;
        logic [BIT_W-1:0] hi_bit;
    } scan_req_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
    } scan_res_t;

endpackage

FILE: src/bitmap_page_frame_allocator_core.sv
// Page frame allocator with a used/free bitmap and a next-fit search hint.
// Input channel s_*: s_tuser carries the operation (allocate, free by
// virtual address, reserve page, release page), s_tdata the address and
// page number. Result channel m_*: one transfer per input transfer, status
// on m_tuser and the frame address on m_tdata (zero unless allocated).
// Configuration channel cfg_*: index 0 sets the virtual offset, index 1 the
// managed page count; write it only while no operation is in flight.
// One item at a time: s_tready is high only while the sequencer is idle.
// Allocate reads and evaluates one bitmap word at a time, a read and an
// evaluate state per word, through the single bitmap RAM read port and the
// free-bit scan unit, until it finds a free page or reports full. Free,
// reserve and release read the page's word. A finished result sits in the
// output register; the next item is accepted meanwhile, and its result
// waits while m_tready is low.
// After reset the bitmap is swept to all used, one word per cycle, through every
// bitmap word with s_tready low; the hint returns to zero and the registers to
// their reset values.
module bitmap_page_frame_allocator_core #(
    parameter int MAX_PAGES  = 65536,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [79:0]                         s_tdata,   // frame_virtual_address, page_number
    input  logic [bpfa_pkg::OP_W-1:0]           s_tuser,   // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bpfa_pkg::ADDR_W-1:0]         m_tdata,   // alloc_addr
    output logic [bpfa_pkg::STATUS_W-1:0]       m_tuser,   // status
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]         cfg_data
);

    localparam int WORDS = (MAX_PAGES + 63) / 64;
    localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = WIW + bpfa_pkg::BIT_W;
    localparam int NW    = PW + 1;
    localparam int CW    = (NW > bpfa_pkg::RANGE_W) ? NW : bpfa_pkg::RANGE_W;

    localparam int AW = bpfa_pkg::ADDR_W;
    localparam int DW = bpfa_pkg::WORD_W;

    bpfa_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                      offset_reg, offset_next;
    logic [bpfa_pkg::RANGE_W-1:0]       range_reg, range_next;
    logic [NW-1:0]                      hint_reg, hint_next;
    logic [WIW-1:0]                     clr_reg, clr_next;
    logic [bpfa_pkg::OP_W-1:0]          op_reg, op_next;
    logic [AW-1:0]                      fva_reg, fva_next;
    logic [bpfa_pkg::PAGE_NUM_W-1:0]    pnum_reg, pnum_next;
    logic [AW-1:0]                      diff_reg, diff_next;
    logic [PW-1:0]                      page_reg, page_next;
    logic [NW-1:0]                      lo_reg, lo_next;
    logic [NW-1:0]                      hi_reg, hi_next;
    logic [WIW-1:0]                     word_reg, word_next;
    logic                               phase_reg, phase_next;
    logic [bpfa_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [AW-1:0]                      addr_reg, addr_next;
    logic                               m_valid_reg, m_valid_next;
    logic [bpfa_pkg::STATUS_W-1:0]      m_status_reg, m_status_next;
    logic [AW-1:0]                      m_addr_reg, m_addr_next;

    logic [NW-1:0]   limit;
    logic [NW-1:0]   wrap_hi;
    logic [NW-1:0]   hi_m1;
    logic [AW-1:0]   page_wide;
    logic [DW-1:0]   bit_mask;

    logic            ram_we;
    logic [WIW-1:0]  ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic [WIW-1:0]  ram_raddr;
    logic [DW-1:0]   ram_rdata;

    bpfa_pkg::scan_req_t scan_req;
    bpfa_pkg::scan_res_t scan_res;

    bpfa_ram #(
        .WIDTH (DW),
        .DEPTH (WORDS)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpfa_scan u_scan (
        .word_data (ram_rdata),
        .req       (scan_req),
        .res       (scan_res)
    );

    assign limit = (CW'(range_reg) > CW'(MAX_PAGES)) ? NW'(MAX_PAGES) : NW'(range_reg);
    assign wrap_hi   = (hint_reg < limit) ? hint_reg : limit;
    assign hi_m1     = hi_reg - NW'(1);
    assign page_wide = diff_reg >> PAGE_SHIFT;
    assign bit_mask  = DW'(1) << page_reg[bpfa_pkg::BIT_W-1:0];

    assign scan_req.first  = (word_reg == lo_reg[PW-1:bpfa_pkg::BIT_W]);
    assign scan_req.last   = (word_reg == hi_m1[PW-1:bpfa_pkg::BIT_W]);
    assign scan_req.lo_bit = lo_reg[bpfa_pkg::BIT_W-1:0];
    assign scan_req.hi_bit = hi_m1[bpfa_pkg::BIT_W-1:0];

    assign s_tready  = (state_reg == bpfa_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_addr_reg;
    assign m_tuser   = m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bpfa_pkg::ST_CLEAR;
            offset_reg  <= '0;
            range_reg   <= bpfa_pkg::RANGE_RESET;
            hint_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            offset_reg  <= offset_next;
            range_reg   <= range_next;
            hint_reg    <= hint_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        fva_reg      <= fva_next;
        pnum_reg     <= pnum_next;
        diff_reg     <= diff_next;
        page_reg     <= page_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        word_reg     <= word_next;
        phase_reg    <= phase_next;
        status_reg   <= status_next;
        addr_reg     <= addr_next;
        m_status_reg <= m_status_next;
        m_addr_reg   <= m_addr_next;
    end

    always_comb begin
        state_next    = state_reg;
        offset_next   = offset_reg;
        range_next    = range_reg;
        hint_next     = hint_reg;
        clr_next      = clr_reg;
        op_next       = op_reg;
        fva_next      = fva_reg;
        pnum_next     = pnum_reg;
        diff_next     = diff_reg;
        page_next     = page_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        word_next     = word_reg;
        phase_next    = phase_reg;
        status_next   = status_reg;
        addr_next     = addr_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_addr_next   = m_addr_reg;
        ram_we        = 1'b0;
        ram_waddr     = word_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = word_reg;

        if (cfg_valid) begin
            case (cfg_index)
                bpfa_pkg::REG_VIRTUAL_OFFSET: offset_next = cfg_data;
                bpfa_pkg::REG_PAGE_RANGE:     range_next  = cfg_data[bpfa_pkg::RANGE_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            bpfa_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '1;
                clr_next  = clr_reg + WIW'(1);
                if (clr_reg == WIW'(WORDS - 1)) begin
                    state_next = bpfa_pkg::ST_IDLE;
                end
            end
            bpfa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    fva_next   = s_tdata[AW-1:0];
                    pnum_next  = s_tdata[AW +: bpfa_pkg::PAGE_NUM_W];
                    addr_next  = '0;
                    state_next = bpfa_pkg::ST_DECODE;
                end
            end
            bpfa_pkg::ST_DECODE: begin
                case (op_reg)
                    bpfa_pkg::OP_ALLOC: begin
                        if (hint_reg < limit) begin
                            lo_next    = hint_reg;
                            hi_next    = limit;
                            word_next  = hint_reg[PW-1:bpfa_pkg::BIT_W];
                            phase_next = 1'b0;
                            state_next = bpfa_pkg::ST_SCAN_RD;
                        end else if (wrap_hi != '0) begin
                            lo_next    = '0;
                            hi_next    = wrap_hi;
                            word_next  = '0;
                            phase_next = 1'b1;
                            state_next = bpfa_pkg::ST_SCAN_RD;
                        end else begin
                            status_next = bpfa_pkg::STS_FULL;
                            state_next  = bpfa_pkg::ST_DONE;
                        end
                    end
                    bpfa_pkg::OP_FREE: begin
                        diff_next  = fva_reg - offset_reg;
                        state_next = bpfa_pkg::ST_CHECK;
                    end
                    default: begin
                        if (CW'(pnum_reg) < CW'(limit)) begin
                            page_next  = PW'(pnum_reg);
                            state_next = bpfa_pkg::ST_MARK_RD;
                        end else begin
                            status_next = bpfa_pkg::STS_OUT_OF_RANGE;
                            state_next  = bpfa_pkg::ST_DONE;
                        end
                    end
                endcase
            end
            bpfa_pkg::ST_CHECK: begin
                if (page_wide < AW'(limit)) begin
                    page_next  = PW'(page_wide);
                    state_next = bpfa_pkg::ST_MARK_RD;
                end else begin
                    status_next = bpfa_pkg::STS_OUT_OF_RANGE;
                    state_next  = bpfa_pkg::ST_DONE;
                end
            end
            bpfa_pkg::ST_SCAN_RD: begin
                ram_raddr  = word_reg;
                state_next = bpfa_pkg::ST_SCAN_EV;
            end
            bpfa_pkg::ST_SCAN_EV: begin
                if (scan_res.found) begin
                    ram_we     = 1'b1;
                    ram_waddr  = word_reg;
                    ram_wdata  = ram_rdata | (DW'(1) << scan_res.bit_idx);
                    page_next  = {word_reg, scan_res.bit_idx};
                    hint_next  = {1'b0, word_reg, scan_res.bit_idx} + NW'(1);
                    state_next = bpfa_pkg::ST_ADDR;
                end else if (!scan_req.last) begin
                    word_next  = word_reg + WIW'(1);
                    state_next = bpfa_pkg::ST_SCAN_RD;
                end else if (!phase_reg && wrap_hi != '0) begin
                    lo_next    = '0;
                    hi_next    = wrap_hi;
                    word_next  = '0;
                    phase_next = 1'b1;
                    state_next = bpfa_pkg::ST_SCAN_RD;
                end else begin
                    status_next = bpfa_pkg::STS_FULL;
                    state_next  = bpfa_pkg::ST_DONE;
                end
            end
            bpfa_pkg::ST_MARK_RD: begin
                ram_raddr  = page_reg[PW-1:bpfa_pkg::BIT_W];
                state_next = bpfa_pkg::ST_MARK_EV;
            end
            bpfa_pkg::ST_MARK_EV: begin
                ram_waddr  = page_reg[PW-1:bpfa_pkg::BIT_W];
                state_next = bpfa_pkg::ST_DONE;
                case (op_reg)
                    bpfa_pkg::OP_FREE: begin
                        if ((ram_rdata & bit_mask) != '0) begin
                            ram_we      = 1'b1;
                            ram_wdata   = ram_rdata & ~bit_mask;
                            status_next = bpfa_pkg::STS_FREED;
                            if ({1'b0, page_reg} < hint_reg) begin
                                hint_next = {1'b0, page_reg};
                            end
                        end else begin
                            status_next = bpfa_pkg::STS_ALREADY_FREE;
                        end
                    end
                    bpfa_pkg::OP_RESERVE: begin
                        ram_we      = 1'b1;
                        ram_wdata   = ram_rdata | bit_mask;
                        status_next = bpfa_pkg::STS_MARKED;
                    end
                    default: begin
                        ram_we      = 1'b1;
                        ram_wdata   = ram_rdata & ~bit_mask;
                        status_next = bpfa_pkg::STS_MARKED;
                    end
                endcase
            end
            bpfa_pkg::ST_ADDR: begin
                addr_next   = (AW'(page_reg) << PAGE_SHIFT) + offset_reg;
                status_next = bpfa_pkg::STS_ALLOCATED;
                state_next  = bpfa_pkg::ST_DONE;
            end
            bpfa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_addr_next   = addr_reg;
                    state_next    = bpfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/bpfa_ram.sv
module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/bpfa_scan.sv
module bpfa_scan (
    input  logic [bpfa_pkg::WORD_W-1:0] word_data,
    input  bpfa_pkg::scan_req_t         req,
    output bpfa_pkg::scan_res_t         res
);

    logic [bpfa_pkg::WORD_W-1:0] lo_mask;
    logic [bpfa_pkg::WORD_W-1:0] hi_mask;
    logic [bpfa_pkg::WORD_W-1:0] free_bits;

    assign lo_mask   = req.first ? ({bpfa_pkg::WORD_W{1'b1}} << req.lo_bit)
                                 : {bpfa_pkg::WORD_W{1'b1}};
    assign hi_mask   = req.last  ? ({bpfa_pkg::WORD_W{1'b1}} >> (6'd63 - req.hi_bit))
                                 : {bpfa_pkg::WORD_W{1'b1}};
    assign free_bits = ~word_data & lo_mask & hi_mask;

    always_comb begin
        res.found   = |free_bits;
        res.bit_idx = '0;
        for (int i = bpfa_pkg::WORD_W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                res.bit_idx = 6'(i);
            end
        end
    end

endmodule

FILE: src/bpfa_check.sv
`include "assert_macros.svh"

module bpfa_check (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bpfa_pkg::ADDR_W-1:0]    m_tdata,
    input logic [bpfa_pkg::STATUS_W-1:0]  m_tuser
);

    `ASSERT_PROP(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result changed while stalled")

    `ASSERT_PROP(a_addr_zero, aclk, aresetn,
        m_tvalid && (m_tuser != bpfa_pkg::STS_ALLOCATED) |-> m_tdata == '0,
        "nonzero address on a non-allocate result")

    `ASSERT_NEVER(a_status_code, aclk, aresetn,
        m_tvalid && (m_tuser > bpfa_pkg::STS_OUT_OF_RANGE),
        "undefined status code")

    `ASSERT_PROP(a_one_at_a_time, aclk, aresetn,
        s_tvalid && s_tready |=> !s_tready,
        "input taken while an item is in progress")

endmodule

bind bitmap_page_frame_allocator_core bpfa_check u_bpfa_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    localparam int MAX_PAGES  = 65536;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_WORDS = (MAX_PAGES + 63) / 64;
    localparam int DIR_ROWS   = 27;
    localparam int PHASES     = 9;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } frame_result_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [ADDR_W-1:0]     value;     // register data, or virtual address of a free
        logic [OP_W-1:0]       op;
        logic [PAGE_NUM_W-1:0] page;
        bit                    typed;
        logic [STATUS_W-1:0]   status;
        logic [ADDR_W-1:0]     frame;
    } step_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata = '0;     // frame_virtual_address, page_number
    logic [OP_W-1:0]       s_tuser = OP_ALLOC;  // op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [ADDR_W-1:0]     m_tdata;          // alloc_addr
    logic [STATUS_W-1:0]   m_tuser;          // status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_VIRTUAL_OFFSET;
    logic [ADDR_W-1:0]     cfg_data = '0;

    bit [63:0]             used_words [PAGE_WORDS];
    logic [RANGE_W-1:0]    search_start;
    logic [ADDR_W-1:0]     window_base;
    logic [RANGE_W-1:0]    managed_range;
    int unsigned           held_pages [$];
    frame_result_t         expected_frames [$];
    int unsigned           results_seen = 0;
    int unsigned           errors = 0;
    bit                    calm = 1'b0;

    step_row_t dir_table [DIR_ROWS] = '{
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_ALLOC, 16'd0, 1'b1, STS_FULL, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_FREE, 16'd0, 1'b1, STS_FREED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_FREE, 16'd0, 1'b1, STS_ALREADY_FREE,
          64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_ALLOC, 16'd0, 1'b1, STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF, OP_FREE, 16'd0, 1'b1,
          STS_OUT_OF_RANGE, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_RELEASE, 16'hFFFF, 1'b1, STS_MARKED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_ALLOC, 16'd0, 1'b0, STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_RELEASE, 16'd5, 1'b1, STS_MARKED, 64'h0},
        '{ROW_CFG, REG_PAGE_RANGE, 64'd100, OP_ALLOC, 16'd0, 1'b0, STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_ALLOC, 16'd0, 1'b0, STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h2ABC, OP_FREE, 16'd0, 1'b0, STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_ALLOC, 16'd0, 1'b0, STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_RESERVE, 16'd100, 1'b1, STS_OUT_OF_RANGE,
          64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_RELEASE, 16'd99, 1'b1, STS_MARKED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_RESERVE, 16'd99, 1'b1, STS_MARKED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_RELEASE, 16'hFFFF, 1'b1, STS_OUT_OF_RANGE,
          64'h0},
        '{ROW_CFG, REG_VIRTUAL_OFFSET, 64'hFFFF_FFFF_FFFF_F000, OP_ALLOC, 16'd0, 1'b0,
          STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_RELEASE, 16'd0, 1'b1, STS_MARKED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_ALLOC, 16'd0, 1'b0, STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_FREE, 16'd0, 1'b0, STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'hFFFF_FFFF_FFFF_EFFF, OP_FREE, 16'd0, 1'b1,
          STS_OUT_OF_RANGE, 64'h0},
        '{ROW_CFG, REG_PAGE_RANGE, 64'd0, OP_ALLOC, 16'd0, 1'b0, STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_ALLOC, 16'd0, 1'b1, STS_FULL, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_RESERVE, 16'd0, 1'b1, STS_OUT_OF_RANGE,
          64'h0},
        '{ROW_CFG, REG_PAGE_RANGE, 64'h1FFFF, OP_ALLOC, 16'd0, 1'b0, STS_ALLOCATED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0, OP_RESERVE, 16'hFFFF, 1'b1, STS_MARKED, 64'h0},
        '{ROW_ITEM, REG_VIRTUAL_OFFSET, 64'h0FFF_E000, OP_FREE, 16'd0, 1'b0, STS_ALLOCATED,
          64'h0}
    };

    int unsigned phase_range [PHASES] = '{64, 1, 200, 65, 0, 65536, 131071, 0, 127};
    int unsigned phase_items [PHASES] = '{200, 60, 300, 200, 300, 40, 30, 30, 390};

    bitmap_page_frame_allocator_core #(
        .MAX_PAGES (MAX_PAGES),
        .PAGE_SHIFT(PAGE_SHIFT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned page_count();
        return (managed_range > MAX_PAGES) ? MAX_PAGES : int'(managed_range);
    endfunction

    function automatic bit page_used(int unsigned p);
        return used_words[p / 64][p % 64];
    endfunction

    function automatic int unsigned first_free_page(int unsigned lo, int unsigned hi);
        int unsigned i;
        i = lo;
        while (i < hi) begin
            if ((i % 64) == 0 && hi - i >= 64 && used_words[i / 64] == '1) begin
                i += 64;
            end else if (!page_used(i)) begin
                return i;
            end else begin
                i++;
            end
        end
        return hi;
    endfunction

    function automatic void predict_frame(input logic [OP_W-1:0] op,
                                          input logic [ADDR_W-1:0] va,
                                          input logic [PAGE_NUM_W-1:0] pg,
                                          output frame_result_t r);
        int unsigned n;
        int unsigned wrap_end;
        int unsigned p;
        logic [ADDR_W-1:0] rel;
        n = page_count();
        r.status = STS_OUT_OF_RANGE;
        r.addr = '0;
        case (op)
            OP_ALLOC: begin
                wrap_end = (search_start < n) ? int'(search_start) : n;
                p = n;
                if (search_start < n) p = first_free_page(search_start, n);
                if (p >= n) begin
                    p = first_free_page(0, wrap_end);
                    if (p >= wrap_end) p = n;
                end
                if (p < n) begin
                    used_words[p / 64][p % 64] = 1'b1;
                    search_start = RANGE_W'(p + 1);
                    r.status = STS_ALLOCATED;
                    r.addr = (64'(p) << PAGE_SHIFT) + window_base;
                    held_pages.push_back(p);
                end else begin
                    r.status = STS_FULL;
                end
            end
            OP_FREE: begin
                rel = (va - window_base) >> PAGE_SHIFT;
                if (rel < 64'(n)) begin
                    p = int'(rel);
                    if (page_used(p)) begin
                        used_words[p / 64][p % 64] = 1'b0;
                        if (p < search_start) search_start = RANGE_W'(p);
                        r.status = STS_FREED;
                    end else begin
                        r.status = STS_ALREADY_FREE;
                    end
                end
            end
            default: begin
                if (pg < n) begin
                    used_words[pg / 64][pg % 64] = (op == OP_RESERVE);
                    r.status = STS_MARKED;
                end
            end
        endcase
    endfunction

    task automatic push_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] va,
                             input logic [PAGE_NUM_W-1:0] pg, input bit typed,
                             input logic [STATUS_W-1:0] t_status,
                             input logic [ADDR_W-1:0] t_addr);
        frame_result_t r;
        if (!calm && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 13);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pg, va};
        do @(posedge aclk); while (!s_tready);
        predict_frame(op, va, pg, r);
        if (typed) begin
            r.status = t_status;
            r.addr = t_addr;
        end
        expected_frames.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_VIRTUAL_OFFSET) window_base = data;
        else if (idx == REG_PAGE_RANGE) managed_range = data[RANGE_W-1:0];
    endtask

    task automatic random_request();
        int unsigned n;
        int unsigned r;
        int unsigned k;
        bit in_window;
        logic [OP_W-1:0] op;
        logic [ADDR_W-1:0] va;
        logic [PAGE_NUM_W-1:0] pg;
        n = page_count();
        r = $urandom_range(0, 99);
        op = (r < 35) ? OP_ALLOC : (r < 60) ? OP_FREE : (r < 80) ? OP_RELEASE : OP_RESERVE;
        va = {$urandom, $urandom};
        pg = PAGE_NUM_W'($urandom);
        in_window = 1'b0;
        r = $urandom_range(0, 99);
        if (held_pages.size() != 0 && r < 55) begin
            k = $urandom_range(0, held_pages.size() - 1);
            pg = PAGE_NUM_W'(held_pages[k]);
            if (op == OP_FREE || op == OP_RELEASE) held_pages.delete(k);
            in_window = 1'b1;
        end else if (n != 0 && r < 85) begin
            pg = PAGE_NUM_W'($urandom_range(0, n - 1));
            in_window = 1'b1;
        end
        if (in_window)
            va = (64'(pg) << PAGE_SHIFT) + window_base + 64'($urandom_range(0, 4095));
        push_item(op, va, pg, 1'b0, STS_ALLOCATED, '0);
    endtask

    always @(posedge aclk) begin
        frame_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_frames.size() == 0) begin
                $display("%0t: result with none pending: expected none, actual status %0d addr %h",
                         $realtime, m_tuser, m_tdata);
                errors++;
            end else begin
                e = expected_frames.pop_front();
                if (m_tuser !== e.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $realtime, e.status, m_tuser);
                    errors++;
                end
                if (m_tdata !== e.addr) begin
                    $display("%0t: frame address mismatch: expected %h, actual %h",
                             $realtime, e.addr, m_tdata);
                    errors++;
                end
            end
        end
    end

    initial begin
        bit held_off;
        held_off = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (!held_off && results_seen >= 300) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 13);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] range_word;
        foreach (used_words[w]) used_words[w] = '1;
        search_start = '0;
        window_base = '0;
        managed_range = RANGE_RESET;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG)
                write_reg(dir_table[i].reg_idx, dir_table[i].value);
            else
                push_item(dir_table[i].op, dir_table[i].value, dir_table[i].page,
                          dir_table[i].typed, dir_table[i].status, dir_table[i].frame);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0, 7: base = '0;
                1: base = '1;
                3: base = 64'hFFFF_FFFF_FFFF_F000;
                default: base = {$urandom, $urandom};
            endcase
            range_word = {$urandom, $urandom};
            range_word[RANGE_W-1:0] = (ph == 4) ? RANGE_W'($urandom_range(1, 1500))
                                                : RANGE_W'(phase_range[ph]);
            write_reg(REG_VIRTUAL_OFFSET, base);
            write_reg(REG_PAGE_RANGE, range_word);
            calm = (ph == 4);
            repeat (phase_items[ph]) random_request();
        end

        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: bitmap_page_frame_allocator_core.f
+incdir+src
src/bpfa_pkg.sv
src/bpfa_ram.sv
src/bpfa_scan.sv
src/bitmap_page_frame_allocator_core.sv
src/bpfa_check.sv
sim/tb.sv
